@@ hw/rtl/lfsc_pkg.sv @@
package lfsc_pkg;

    // Field widths.
    localparam int DUTY_W   = 15;
    localparam int COEF_W   = 16;
    localparam int ANGLE_W  = 14;
    localparam int NLANG_W  = 13;
    localparam int POS_W    = 7;
    localparam int DIR_W    = 2;
    localparam int GAIN_W   = 12;
    localparam int BANDS_W  = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Derived widths.
    localparam int ERR_W   = POS_W + 1;          // signed position error
    localparam int MAG_W   = POS_W;              // |error| up to 64
    localparam int PROD_W  = MAG_W + COEF_W;     // duty drop
    localparam int DIFF_W  = PROD_W + 2;         // signed duty before clamping
    localparam int STEER_W = GAIN_W + 1 + ERR_W; // signed gain times error
    localparam int BAND_W  = 4;

    // Controller constants.
    localparam int POS_CENTER  = 64;
    localparam int ANGLE_LIMIT = 7680;
    localparam int BAND_STEP   = 2560;
    localparam int BAND_LAST   = 9;
    localparam int BANDS_PER_WORD = 5;

    // Last-seen direction codes.
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_MIDDLE = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd2;

    // Register reset values.
    localparam logic [DUTY_W-1:0]  RST_DUTY_MAX     = 15'd12800;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MIN     = 15'd5120;
    localparam logic [COEF_W-1:0]  RST_COEF_LOW     = 16'd256;
    localparam logic [COEF_W-1:0]  RST_COEF_HIGH    = 16'd512;
    localparam logic [DUTY_W-1:0]  RST_NOLINE_DUTY  = 15'd7680;
    localparam logic [NLANG_W-1:0] RST_NOLINE_ANGLE = 13'd7680;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_MAX        = 3'd0,
        REG_DUTY_MIN        = 3'd1,
        REG_COEF_LOW        = 3'd2,
        REG_COEF_HIGH       = 3'd3,
        REG_NOLINE_DUTY     = 3'd4,
        REG_NOLINE_ANGLE    = 3'd5,
        REG_GAIN_BANDS_LOW  = 3'd6,
        REG_GAIN_BANDS_HIGH = 3'd7
    } cfg_index_t;

    // Current register contents, as seen by the datapath.
    typedef struct packed {
        logic [DUTY_W-1:0]  duty_max;
        logic [DUTY_W-1:0]  duty_min;
        logic [COEF_W-1:0]  coef_low;
        logic [COEF_W-1:0]  coef_high;
        logic [DUTY_W-1:0]  noline_duty;
        logic [NLANG_W-1:0] noline_angle;
        logic [BANDS_W-1:0] gain_bands_low;
        logic [BANDS_W-1:0] gain_bands_high;
    } cfg_t;

endpackage

@@ hw/rtl/lfsc_cfg_regs.sv @@
module lfsc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lfsc_pkg::cfg_t                     cfg
);
    import lfsc_pkg::*;

    cfg_t cfg_reg;

    // Every register takes a write in the cycle it is offered.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file; each transfer updates the register selected by its index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_max        <= RST_DUTY_MAX;
            cfg_reg.duty_min        <= RST_DUTY_MIN;
            cfg_reg.coef_low        <= RST_COEF_LOW;
            cfg_reg.coef_high       <= RST_COEF_HIGH;
            cfg_reg.noline_duty     <= RST_NOLINE_DUTY;
            cfg_reg.noline_angle    <= RST_NOLINE_ANGLE;
            cfg_reg.gain_bands_low  <= '0;
            cfg_reg.gain_bands_high <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DUTY_MAX:        cfg_reg.duty_max        <= cfg_data[DUTY_W-1:0];
                REG_DUTY_MIN:        cfg_reg.duty_min        <= cfg_data[DUTY_W-1:0];
                REG_COEF_LOW:        cfg_reg.coef_low        <= cfg_data[COEF_W-1:0];
                REG_COEF_HIGH:       cfg_reg.coef_high       <= cfg_data[COEF_W-1:0];
                REG_NOLINE_DUTY:     cfg_reg.noline_duty     <= cfg_data[DUTY_W-1:0];
                REG_NOLINE_ANGLE:    cfg_reg.noline_angle    <= cfg_data[NLANG_W-1:0];
                REG_GAIN_BANDS_LOW:  cfg_reg.gain_bands_low  <= cfg_data[BANDS_W-1:0];
                REG_GAIN_BANDS_HIGH: cfg_reg.gain_bands_high <= cfg_data[BANDS_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/line_follow_speed_steer_controller.sv @@
// Channel   Handshake                Payload
// -------   ---------------------    ------------------------------------------
// input     in_valid / in_ready      line_found, line_pos, last_side
// output    out_valid / out_ready    left_duty, right_duty, steer_angle
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Four register stages: duty-drop multiply, subtract and clamp, band lookup,
// steering multiply and clamp. One item per cycle while the output is not stalled.
// Each stage holds its item while the stage after it is full and stalled, so a
// stall on the output backs up stage by stage and bubbles are squeezed out.
// Reset clears all stage valid bits and loads the register reset values.
module line_follow_speed_steer_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  line_found,
    input  logic [lfsc_pkg::POS_W-1:0]            line_pos,
    input  logic [lfsc_pkg::DIR_W-1:0]            last_side,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lfsc_pkg::DUTY_W-1:0]           left_duty,
    output logic [lfsc_pkg::DUTY_W-1:0]           right_duty,
    output logic signed [lfsc_pkg::ANGLE_W-1:0]   steer_angle
);
    import lfsc_pkg::*;

    cfg_t cfg;

    lfsc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valid bits and per-stage advance.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: position error and the duty drop of each wheel.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  s1_err_next;
    logic [MAG_W-1:0]         s1_mag;
    logic [COEF_W-1:0]        s1_coef_left, s1_coef_right;
    logic [PROD_W-1:0]        s1_drop_left_next, s1_drop_right_next;

    logic                     s1_found_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic [DIR_W-1:0]         s1_dir_reg;
    logic [PROD_W-1:0]        s1_drop_left_reg, s1_drop_right_reg;

    always_comb
    begin
        s1_err_next = $signed({1'b0, line_pos}) - ERR_W'(POS_CENTER);
        s1_mag      = s1_err_next[ERR_W-1] ? MAG_W'(-s1_err_next) : MAG_W'(s1_err_next);
        // The wheel on the side away from the line slows down more.
        if (s1_err_next > 0)
        begin
            s1_coef_left  = cfg.coef_high;
            s1_coef_right = cfg.coef_low;
        end
        else
        begin
            s1_coef_left  = cfg.coef_low;
            s1_coef_right = cfg.coef_high;
        end
        s1_drop_left_next  = PROD_W'(s1_mag) * PROD_W'(s1_coef_left);
        s1_drop_right_next = PROD_W'(s1_mag) * PROD_W'(s1_coef_right);
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_found_reg      <= line_found;
            s1_err_reg        <= s1_err_next;
            s1_dir_reg        <= last_side;
            s1_drop_left_reg  <= s1_drop_left_next;
            s1_drop_right_reg <= s1_drop_right_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: subtract from the maximum duty and clamp; the upper limit
    // is applied last so the maximum wins over a larger minimum.
    // ------------------------------------------------------------------
    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic [PROD_W-1:0] drop,
        input logic [DUTY_W-1:0] dmax,
        input logic [DUTY_W-1:0] dmin
    );
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] res;
        diff = $signed({{(DIFF_W-DUTY_W){1'b0}}, dmax}) - $signed({2'b00, drop});
        res  = diff;
        if (res < $signed({{(DIFF_W-DUTY_W){1'b0}}, dmin}))
            res = $signed({{(DIFF_W-DUTY_W){1'b0}}, dmin});
        if (res > $signed({{(DIFF_W-DUTY_W){1'b0}}, dmax}))
            res = $signed({{(DIFF_W-DUTY_W){1'b0}}, dmax});
        return res[DUTY_W-1:0];
    endfunction

    logic [DUTY_W-1:0]        s2_left_next, s2_right_next;

    logic                     s2_found_reg;
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic [DIR_W-1:0]         s2_dir_reg;
    logic [DUTY_W-1:0]        s2_left_reg, s2_right_reg;

    always_comb
    begin
        if (s1_found_reg)
        begin
            s2_left_next  = clamp_duty(s1_drop_left_reg, cfg.duty_max, cfg.duty_min);
            s2_right_next = clamp_duty(s1_drop_right_reg, cfg.duty_max, cfg.duty_min);
        end
        else
        begin
            s2_left_next  = cfg.noline_duty;
            s2_right_next = cfg.noline_duty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_found_reg <= s1_found_reg;
            s2_err_reg   <= s1_err_reg;
            s2_dir_reg   <= s1_dir_reg;
            s2_left_reg  <= s2_left_next;
            s2_right_reg <= s2_right_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: 10% band of the left duty and its steering gain. The band
    // counts the band edges strictly below the duty, saturating at the last.
    // ------------------------------------------------------------------
    logic [BAND_W-1:0]        s3_band;
    logic [GAIN_W-1:0]        s3_gain_next;

    logic                     s3_found_reg;
    logic signed [ERR_W-1:0]  s3_err_reg;
    logic [DIR_W-1:0]         s3_dir_reg;
    logic [DUTY_W-1:0]        s3_left_reg, s3_right_reg;
    logic [GAIN_W-1:0]        s3_gain_reg;

    always_comb
    begin
        s3_band = '0;
        for (int k = 1; k <= BAND_LAST; k++)
        begin
            if (s2_left_reg > DUTY_W'(k * BAND_STEP))
                s3_band = s3_band + 1'b1;
        end
        s3_gain_next = '0;
        for (int k = 0; k < BANDS_PER_WORD; k++)
        begin
            if (s3_band == BAND_W'(k))
                s3_gain_next = cfg.gain_bands_low[k*GAIN_W +: GAIN_W];
            if (s3_band == BAND_W'(k + BANDS_PER_WORD))
                s3_gain_next = cfg.gain_bands_high[k*GAIN_W +: GAIN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_found_reg <= s2_found_reg;
            s3_err_reg   <= s2_err_reg;
            s3_dir_reg   <= s2_dir_reg;
            s3_left_reg  <= s2_left_reg;
            s3_right_reg <= s2_right_reg;
            s3_gain_reg  <= s3_gain_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: steering angle, clamped to thirty degrees either way. With
    // no line, the angle follows the side where the line was last seen.
    // ------------------------------------------------------------------
    logic signed [STEER_W-1:0] s4_prod;
    logic [NLANG_W-1:0]        s4_lost_mag;
    logic signed [ANGLE_W-1:0] s4_angle_next;

    logic [DUTY_W-1:0]         s4_left_reg, s4_right_reg;
    logic signed [ANGLE_W-1:0] s4_angle_reg;

    always_comb
    begin
        s4_prod = $signed({1'b0, s3_gain_reg}) * STEER_W'(s3_err_reg);
        s4_lost_mag = (cfg.noline_angle > NLANG_W'(ANGLE_LIMIT)) ?
                      NLANG_W'(ANGLE_LIMIT) : cfg.noline_angle;
        if (s3_found_reg)
        begin
            if (s4_prod > STEER_W'(ANGLE_LIMIT))
                s4_angle_next = ANGLE_W'(ANGLE_LIMIT);
            else if (s4_prod < -STEER_W'(ANGLE_LIMIT))
                s4_angle_next = -ANGLE_W'(ANGLE_LIMIT);
            else
                s4_angle_next = s4_prod[ANGLE_W-1:0];
        end
        else
        begin
            priority if (s3_dir_reg == DIR_RIGHT)
                s4_angle_next = $signed({1'b0, s4_lost_mag});
            else if (s3_dir_reg == DIR_MIDDLE)
                s4_angle_next = '0;
            else
                s4_angle_next = -$signed({1'b0, s4_lost_mag});
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_left_reg  <= s3_left_reg;
            s4_right_reg <= s3_right_reg;
            s4_angle_reg <= s4_angle_next;
        end
    end

    assign out_valid   = s4_valid_reg;
    assign left_duty   = s4_left_reg;
    assign right_duty  = s4_right_reg;
    assign steer_angle = s4_angle_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A delivered angle never exceeds thirty degrees either way.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (steer_angle <= ANGLE_W'(ANGLE_LIMIT)) &&
                      (steer_angle >= -ANGLE_W'(ANGLE_LIMIT)))
        else $error("steer angle out of range");

    // An empty output stage lets the whole pipeline take a new item.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output stage");

    // With every stage full and the output stalled, no transfer is taken in.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid && !out_ready)
        |-> !in_ready)
        else $error("input taken into a full stalled pipeline");

    // A stalled result is not overwritten by the item behind it.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(s4_angle_reg) &&
                                      $stable(s4_left_reg))
        else $error("stalled result changed");

endmodule
